### src/hbev_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbev_pkg
// Shared constants and types of the bird's-eye-view homography remap block.
// ----------------------------------------------------------------------------
package hbev_pkg;

  // Frame store and BEV grid sizes
  localparam int SRC_ROWS_MAX = 512;
  localparam int SRC_COLS_MAX = 2048;
  localparam int BEV_ROWS     = 1024;
  localparam int BEV_COLS     = 512;

  localparam int ROW_AW   = $clog2(SRC_ROWS_MAX);
  localparam int COL_AW   = $clog2(SRC_COLS_MAX);
  localparam int ADDR_W   = ROW_AW + COL_AW;
  localparam int FRAME_SZ = SRC_ROWS_MAX * SRC_COLS_MAX;

  // Quotient width: large enough to exceed the biggest source size
  localparam int QMAX = (SRC_ROWS_MAX > SRC_COLS_MAX) ? SRC_ROWS_MAX : SRC_COLS_MAX;
  localparam int QB   = $clog2(QMAX + 1);

  // Datapath widths
  localparam int POS_W  = 11;
  localparam int PIX_W  = 8;
  localparam int COEF_W = 32;
  localparam int PROD_W = COEF_W + POS_W + 1;
  localparam int SUM_W  = PROD_W + 2;

  // Register indexes on the configuration port
  localparam int CFG_AW = 3;
  typedef enum logic [CFG_AW-1:0] {
    REG_H00_H01 = 3'd0,
    REG_H02_H10 = 3'd1,
    REG_H11_H12 = 3'd2,
    REG_H20_H21 = 3'd3,
    REG_H22     = 3'd4,
    REG_SRC_ROWS = 3'd5,
    REG_SRC_COLS = 3'd6
  } cfg_reg_t;

  // Item actions
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_MAP  = 1'b1;

  // Item information that travels beside the arithmetic
  typedef struct packed {
    logic             act;
    logic             ok;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic [PIX_W-1:0] pix;
  } side_t;

  // One result word in the output queue
  typedef struct packed {
    logic             in_view;
    logic [PIX_W-1:0] pix;
  } res_t;

endpackage

### src/homography_bev_remap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// homography_bev_remap
// Bird's-eye-view remap of an 8-bit gray image through a 3x3 homography.
// ----------------------------------------------------------------------------
// Usage:
//   The in_ channel carries load words (in_tuser = 0) that write one source
//   pixel into the frame store, and map words (in_tuser = 1) that give a BEV
//   row and column. Each map word yields one out_ word holding the source
//   pixel at the projected point, or 0 with out_tuser clear when the point
//   lies outside the configured source size. Load words yield nothing.
//   Coefficients and sizes are written on the cfg_ port while idle.
// Timing:
//   One word is accepted per cycle while in_tready is high. A map result is
//   registered through the capture, product, sum and magnitude stages, one
//   quotient bit per stage in the two 12-stage dividers, the range check and
//   the frame store read, then written into the output queue; it can leave
//   the queue in the cycle after that write.
// Stalls and reset:
//   The pipeline never stops; a 32-word output queue absorbs results and
//   in_tready falls only when every queue slot is reserved by words in
//   flight. Reset presets the control registers and the queue; the frame store is not
//   cleared, and a pixel must be loaded before it is read.
// ----------------------------------------------------------------------------
module homography_bev_remap (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // pos_row[10:0], pos_col[21:11], pixel_in[29:22]
  input  logic        in_tuser,   // action
  // Result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // bev_pixel[7:0]
  output logic        out_tuser,  // in_view
  // Configuration port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [63:0] cfg_wdata
);

  localparam int POS_W  = hbev_pkg::POS_W;
  localparam int PIX_W  = hbev_pkg::PIX_W;
  localparam int COEF_W = hbev_pkg::COEF_W;
  localparam int PROD_W = hbev_pkg::PROD_W;
  localparam int SUM_W  = hbev_pkg::SUM_W;
  localparam int QB     = hbev_pkg::QB;
  localparam int ADDR_W = hbev_pkg::ADDR_W;
  localparam int ROW_AW = hbev_pkg::ROW_AW;
  localparam int COL_AW = hbev_pkg::COL_AW;
  localparam int CRED   = 32;
  localparam int CW     = $clog2(CRED + 1);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [63:0] h00_h01_r, h02_h10_r, h11_h12_r, h20_h21_r;
  logic [31:0] h22_r;
  logic [9:0]  src_rows_r;
  logic [11:0] src_cols_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h00_h01_r  <= '0;
      h02_h10_r  <= '0;
      h11_h12_r  <= '0;
      h20_h21_r  <= '0;
      h22_r      <= 32'd65536;
      src_rows_r <= 10'd375;
      src_cols_r <= 12'd1242;
    end else if (cfg_we) begin
      unique case (hbev_pkg::cfg_reg_t'(cfg_addr))
        hbev_pkg::REG_H00_H01:  h00_h01_r  <= cfg_wdata;
        hbev_pkg::REG_H02_H10:  h02_h10_r  <= cfg_wdata;
        hbev_pkg::REG_H11_H12:  h11_h12_r  <= cfg_wdata;
        hbev_pkg::REG_H20_H21:  h20_h21_r  <= cfg_wdata;
        hbev_pkg::REG_H22:      h22_r      <= cfg_wdata[31:0];
        hbev_pkg::REG_SRC_ROWS: src_rows_r <= cfg_wdata[9:0];
        hbev_pkg::REG_SRC_COLS: src_cols_r <= cfg_wdata[11:0];
        default: ;
      endcase
    end
  end

  logic signed [COEF_W-1:0] h00, h01, h02, h10, h11, h12, h20, h21, h22;
  assign h00 = signed'(h00_h01_r[63:32]);
  assign h01 = signed'(h00_h01_r[31:0]);
  assign h02 = signed'(h02_h10_r[63:32]);
  assign h10 = signed'(h02_h10_r[31:0]);
  assign h11 = signed'(h11_h12_r[63:32]);
  assign h12 = signed'(h11_h12_r[31:0]);
  assign h20 = signed'(h20_h21_r[63:32]);
  assign h21 = signed'(h20_h21_r[31:0]);
  assign h22 = signed'(h22_r);

  // Source size limits, saturated to the store size
  logic [QB-1:0] lim_r, lim_c;
  assign lim_r = (src_rows_r > 10'(hbev_pkg::SRC_ROWS_MAX)) ?
                 QB'(hbev_pkg::SRC_ROWS_MAX) : QB'(src_rows_r);
  assign lim_c = (src_cols_r > 12'(hbev_pkg::SRC_COLS_MAX)) ?
                 QB'(hbev_pkg::SRC_COLS_MAX) : QB'(src_cols_r);

  // --------------------------------------------------------------------------
  // Slot reservation in the output queue
  // --------------------------------------------------------------------------
  logic          in_acc, out_acc, drop;
  logic [CW-1:0] cred_r, cred_nxt;

  assign in_tready = (cred_r < CW'(CRED));
  assign in_acc    = in_tvalid && in_tready;
  assign out_acc   = out_tvalid && out_tready;

  always_comb begin
    cred_nxt = cred_r + CW'(in_acc) - CW'(drop) - CW'(out_acc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cred_r <= '0;
    end else begin
      cred_r <= cred_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: capture the word
  // --------------------------------------------------------------------------
  logic            s1_v_r;
  hbev_pkg::side_t s1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    s1_r.act <= in_tuser;
    s1_r.ok  <= 1'b0;
    s1_r.row <= in_tdata[10:0];
    s1_r.col <= in_tdata[21:11];
    s1_r.pix <= in_tdata[29:22];
  end

  // --------------------------------------------------------------------------
  // Stage 2: six products and the grid check
  // --------------------------------------------------------------------------
  logic                     s2_v_r;
  hbev_pkg::side_t          s2_r;
  logic signed [PROD_W-1:0] p_xr_r, p_xc_r, p_yr_r, p_yc_r, p_wr_r, p_wc_r;
  logic signed [POS_W:0]    row_s, col_s;

  assign row_s = signed'({1'b0, s1_r.row});
  assign col_s = signed'({1'b0, s1_r.col});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_r.act <= s1_r.act;
    s2_r.ok  <= ({1'b0, s1_r.row} < (POS_W+1)'(hbev_pkg::BEV_ROWS)) &&
                ({1'b0, s1_r.col} < (POS_W+1)'(hbev_pkg::BEV_COLS));
    s2_r.row <= s1_r.row;
    s2_r.col <= s1_r.col;
    s2_r.pix <= s1_r.pix;
    p_xr_r   <= h00 * row_s;
    p_xc_r   <= h01 * col_s;
    p_yr_r   <= h10 * row_s;
    p_yc_r   <= h11 * col_s;
    p_wr_r   <= h20 * row_s;
    p_wc_r   <= h21 * col_s;
  end

  // --------------------------------------------------------------------------
  // Stage 3: x, y and w sums
  // --------------------------------------------------------------------------
  logic                    s3_v_r;
  hbev_pkg::side_t         s3_r;
  logic signed [SUM_W-1:0] x_r, y_r, w_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_r <= s2_r;
    x_r  <= SUM_W'(p_xr_r) + SUM_W'(p_xc_r) + SUM_W'(h02);
    y_r  <= SUM_W'(p_yr_r) + SUM_W'(p_yc_r) + SUM_W'(h12);
    w_r  <= SUM_W'(p_wr_r) + SUM_W'(p_wc_r) + SUM_W'(h22);
  end

  // --------------------------------------------------------------------------
  // Stage 4: magnitudes and quotient pre-checks. A quotient in view is
  // positive and below 2^QB, so the signs must agree and the dividend must
  // stay below the divisor shifted by QB.
  // --------------------------------------------------------------------------
  logic             s4_v_r;
  hbev_pkg::side_t  s4_r;
  logic [SUM_W-1:0] ax, ay, aw;
  logic [SUM_W-1:0] ax_r, ay_r, aw_r;
  logic             okx, oky;

  assign ax = x_r[SUM_W-1] ? SUM_W'(-x_r) : SUM_W'(x_r);
  assign ay = y_r[SUM_W-1] ? SUM_W'(-y_r) : SUM_W'(y_r);
  assign aw = w_r[SUM_W-1] ? SUM_W'(-w_r) : SUM_W'(w_r);

  assign okx = (x_r != '0) && (x_r[SUM_W-1] == w_r[SUM_W-1]) &&
               ({{QB{1'b0}}, ax} < ({{QB{1'b0}}, aw} << QB));
  assign oky = (y_r != '0) && (y_r[SUM_W-1] == w_r[SUM_W-1]) &&
               ({{QB{1'b0}}, ay} < ({{QB{1'b0}}, aw} << QB));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else begin
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s4_r.act <= s3_r.act;
    s4_r.ok  <= s3_r.ok && (w_r != '0) && okx && oky;
    s4_r.row <= s3_r.row;
    s4_r.col <= s3_r.col;
    s4_r.pix <= s3_r.pix;
    ax_r     <= ax;
    ay_r     <= ay;
    aw_r     <= aw;
  end

  // --------------------------------------------------------------------------
  // Dividers, with the word information delayed alongside
  // --------------------------------------------------------------------------
  logic [QB-1:0]   qc, qr;
  logic            dv_v_r [QB];
  hbev_pkg::side_t dv_r   [QB];

  hbev_divider u_div_col (
    .clk      (clk),
    .dividend (ax_r),
    .divisor  (aw_r),
    .quotient (qc)
  );

  hbev_divider u_div_row (
    .clk      (clk),
    .dividend (ay_r),
    .divisor  (aw_r),
    .quotient (qr)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < QB; i++) begin
        dv_v_r[i] <= 1'b0;
      end
    end else begin
      dv_v_r[0] <= s4_v_r;
      for (int i = 1; i < QB; i++) begin
        dv_v_r[i] <= dv_v_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    dv_r[0] <= s4_r;
    for (int i = 1; i < QB; i++) begin
      dv_r[i] <= dv_r[i-1];
    end
  end

  // --------------------------------------------------------------------------
  // Check stage: range test and frame store address
  // --------------------------------------------------------------------------
  hbev_pkg::side_t d_s;
  logic            d_v;
  logic            ck_v_r, ck_map_r, ck_in_r, ck_we_r;
  logic [ADDR_W-1:0] ck_addr_r;
  logic [PIX_W-1:0]  ck_pix_r;
  logic [QB-1:0]   sc, sr;
  logic            map_in, load_ok;

  assign d_s = dv_r[QB-1];
  assign d_v = dv_v_r[QB-1];
  assign sc  = qc - 1'b1;
  assign sr  = qr - 1'b1;

  assign map_in  = d_s.ok && (qc != '0) && (qc <= lim_c) &&
                   (qr != '0) && (qr <= lim_r);
  assign load_ok = ({1'b0, d_s.row} < (POS_W+1)'(hbev_pkg::SRC_ROWS_MAX)) &&
                   ({1'b0, d_s.col} < (POS_W+1)'(hbev_pkg::SRC_COLS_MAX));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ck_v_r  <= 1'b0;
      ck_we_r <= 1'b0;
    end else begin
      ck_v_r  <= d_v;
      ck_we_r <= d_v && (d_s.act == hbev_pkg::ACT_LOAD) && load_ok;
    end
  end

  always_ff @(posedge clk) begin
    ck_map_r <= (d_s.act == hbev_pkg::ACT_MAP);
    ck_in_r  <= map_in;
    ck_pix_r <= d_s.pix;
    if (d_s.act == hbev_pkg::ACT_MAP) begin
      ck_addr_r <= {sr[ROW_AW-1:0], sc[COL_AW-1:0]};
    end else begin
      ck_addr_r <= {d_s.row[ROW_AW-1:0], d_s.col[COL_AW-1:0]};
    end
  end

  // Load words leave the pipeline here and free their slot
  assign drop = ck_v_r && !ck_map_r;

  // --------------------------------------------------------------------------
  // Frame store: loads write and maps read in the same stage, in word order
  // --------------------------------------------------------------------------
  logic [PIX_W-1:0] ram_rdata;
  logic             rd_v_r, rd_in_r;

  hbev_ram #(
    .WIDTH (PIX_W),
    .DEPTH (hbev_pkg::FRAME_SZ)
  ) u_frame (
    .clk   (clk),
    .we    (ck_we_r),
    .addr  (ck_addr_r),
    .wdata (ck_pix_r),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r <= 1'b0;
    end else begin
      rd_v_r <= ck_v_r && ck_map_r;
    end
  end

  always_ff @(posedge clk) begin
    rd_in_r <= ck_in_r;
  end

  // --------------------------------------------------------------------------
  // Output queue
  // --------------------------------------------------------------------------
  hbev_pkg::res_t push_res, head;

  assign push_res.in_view = rd_in_r;
  assign push_res.pix     = rd_in_r ? ram_rdata : '0;

  hbev_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (rd_v_r),
    .push_data (push_res),
    .pop       (out_acc),
    .not_empty (out_tvalid),
    .head      (head)
  );

  assign out_tdata = head.pix;
  assign out_tuser = head.in_view;

endmodule

### src/hbev_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbev_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module hbev_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write or read one entry per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### src/hbev_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbev_divider
// Pipelined restoring divider of two magnitudes, one quotient bit per stage.
// The dividend must be below divisor * 2^QB; the quotient is registered in
// the last of the QB stages.
// ----------------------------------------------------------------------------
module hbev_divider (
  input  logic                            clk,
  input  logic [hbev_pkg::SUM_W-1:0]      dividend,
  input  logic [hbev_pkg::SUM_W-1:0]      divisor,
  output logic [hbev_pkg::QB-1:0]         quotient
);

  localparam int RW = hbev_pkg::SUM_W;
  localparam int QB = hbev_pkg::QB;

  genvar i;
  generate
    for (i = 0; i < QB; i++) begin : g_stage
      logic [RW-1:0]    rem_in;
      logic [RW-1:0]    dv_in;
      logic [QB-1:0]    q_in;
      logic [RW+QB-1:0] shifted;
      logic             take;
      logic [RW-1:0]    rem_r;
      logic [RW-1:0]    dv_r;
      logic [QB-1:0]    q_r;

      if (i == 0) begin : g_first
        assign rem_in = dividend;
        assign dv_in  = divisor;
        assign q_in   = '0;
      end else begin : g_next
        assign rem_in = g_stage[i-1].rem_r;
        assign dv_in  = g_stage[i-1].dv_r;
        assign q_in   = g_stage[i-1].q_r;
      end

      // Trial subtract of the divisor at this bit weight
      assign shifted = {{QB{1'b0}}, dv_in} << (QB - 1 - i);
      assign take    = ({{QB{1'b0}}, rem_in} >= shifted);

      always_ff @(posedge clk) begin
        rem_r <= take ? (rem_in - shifted[RW-1:0]) : rem_in;
        dv_r  <= dv_in;
        q_r   <= {q_in[QB-2:0], take};
      end
    end
  endgenerate

  assign quotient = g_stage[QB-1].q_r;

endmodule

### src/hbev_out_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbev_out_fifo
// Result queue between the remap pipeline and the output channel. The
// pipeline never stalls; the top level reserves a slot per accepted item.
// ----------------------------------------------------------------------------
module hbev_out_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  hbev_pkg::res_t       push_data,
  input  logic                 pop,
  output logic                 not_empty,
  output hbev_pkg::res_t       head
);

  localparam int DEPTH = 32;
  localparam int PW    = $clog2(DEPTH);

  hbev_pkg::res_t  mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]     cnt_r, cnt_nxt;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + {{PW{1'b0}}, push} - {{PW{1'b0}}, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rd_ptr_r];

endmodule
